>>> src/sob_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
package sob_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = 12;
   localparam int DIM_W       = 12;
   localparam int CNT_W       = (COL_W > ROW_W ? COL_W : ROW_W) + 1;
   localparam int LIN_W       = ROW_W + DIM_W + 1;
   localparam int PIX_W       = 8;
   localparam int SUM_W       = PIX_W + 2;
   localparam int GRAD_W      = PIX_W + 3;
   localparam int ABS_W       = PIX_W + 2;
   localparam int SQ_W        = 2 * ABS_W + 1;
   localparam int RT_W        = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_IDX_W   = 2;
   localparam int GRAY_SHIFT  = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd480;

   // floor(x / 3) == (x * 683) >> 11 for every x up to 3 * 255
   localparam logic [SUM_W-1:0] GRAY_RECIP = 10'd683;

   localparam logic [PIX_W-1:0] MAG_MAX    = 8'd255;
   localparam logic [RT_W-1:0]  ROOT_START = 16'h4000;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             drain;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_value;
      logic             frame_end;
   } rsp_type;

   typedef struct packed {
      logic                     border;
      logic                     frame_end;
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
   } q_entry_type;

endpackage

>>> src/sob_front.sv
// Front end: pixel intake, gray conversion, line buffers, window and result classification.
module sob_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sob_pkg::req_type               req_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sob_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sob_pkg::DIM_W-1:0]      csr_wdata,
   input  logic [sob_pkg::QCNT_W-1:0]     q_count,
   output logic                           q_push,
   output sob_pkg::q_entry_type           q_entry
);
   import sob_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic             recalc_ff;
   logic [COL_W-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [LIN_W-1:0] in_base_ff, in_base_in, out_base_ff, out_base_in;
   logic             owed_ff, owed_in;

   logic [DIM_W-1:0] eff_w, eff_h;
   logic [ROW_W+DIM_W-1:0] in_prod, out_prod;
   logic [LIN_W-1:0] in_lin, out_thr;
   logic             req_fire, drain, emit, border;
   logic             out_col_wrap, out_row_wrap, in_col_wrap, in_row_wrap;
   logic [QCNT_W:0]  q_need;

   logic [SUM_W-1:0]        gray_sum;
   logic [2*SUM_W-1:0]      gray_prod;
   logic [PIX_W-1:0]        gray;

   logic             b_valid_ff, b_pix_ff, b_emit_ff, b_border_ff, b_end_ff;
   logic [COL_W-1:0] b_col_ff;
   logic [PIX_W-1:0] b_gray_ff;
   logic             fwd_ff;
   logic [PIX_W-1:0] fwd_top_ff, fwd_mid_ff, top_rd_ff, mid_rd_ff;
   logic             b_wr;
   logic [PIX_W-1:0] top_eff, mid_eff;

   logic [PIX_W-1:0] above_mem     [MAX_WIDTH];
   logic [PIX_W-1:0] two_above_mem [MAX_WIDTH];

   logic [PIX_W-1:0] win_ff   [9];
   logic [PIX_W-1:0] win_next [9];
   logic [SUM_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;

   // effective frame size
   always_comb begin
      if (width_ff == '0) begin
         eff_w = DIM_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = DIM_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      eff_h = (height_ff == '0) ? DIM_W'(1) : height_ff;
   end

   assign csr_ready = 1'b1;
   assign in_prod   = in_row_ff * eff_w;
   assign out_prod  = out_row_ff * eff_w;

   assign q_push    = b_valid_ff && b_emit_ff;
   assign q_need    = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(q_push);
   assign req_stall = recalc_ff || (q_need >= (QCNT_W + 1)'(QUEUE_DEPTH));
   assign req_fire  = req_valid && !req_stall;
   assign drain     = req_payload.drain;

   assign in_lin  = in_base_ff + LIN_W'(in_col_ff);
   assign out_thr = out_base_ff + LIN_W'(out_col_ff) + LIN_W'(eff_w) + LIN_W'(1);
   assign emit    = owed_ff || (!drain && (in_lin >= out_thr));

   assign out_col_wrap = (CNT_W'(out_col_ff) + CNT_W'(1)) >= CNT_W'(eff_w);
   assign out_row_wrap = (CNT_W'(out_row_ff) + CNT_W'(1)) >= CNT_W'(eff_h);
   assign in_col_wrap  = (CNT_W'(in_col_ff) + CNT_W'(1)) >= CNT_W'(eff_w);
   assign in_row_wrap  = (CNT_W'(in_row_ff) + CNT_W'(1)) >= CNT_W'(eff_h);
   assign border       = owed_ff || (out_row_ff == '0) || (out_col_ff == '0) ||
                         out_row_wrap || out_col_wrap;

   assign gray_sum  = SUM_W'(req_payload.red) + SUM_W'(req_payload.green) +
                      SUM_W'(req_payload.blue);
   assign gray_prod = gray_sum * GRAY_RECIP;
   assign gray      = gray_prod[GRAY_SHIFT +: PIX_W];

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_base_in  = in_base_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_base_in = out_base_ff;
      owed_in     = owed_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default:          ;
         endcase
      end

      if (recalc_ff) begin
         in_base_in  = LIN_W'(in_prod);
         out_base_in = LIN_W'(out_prod);
      end

      if (req_fire && emit) begin
         if (out_col_wrap) begin
            out_col_in = '0;
            if (out_row_wrap) begin
               out_row_in  = '0;
               out_base_in = '0;
               owed_in     = 1'b0;
            end else begin
               out_row_in  = out_row_ff + 1'b1;
               out_base_in = out_base_ff + LIN_W'(eff_w);
            end
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end

      if (req_fire && !drain) begin
         if (in_col_wrap) begin
            in_col_in = '0;
            if (in_row_wrap) begin
               in_row_in  = '0;
               in_base_in = '0;
               owed_in    = 1'b1;
            end else begin
               in_row_in  = in_row_ff + 1'b1;
               in_base_in = in_base_ff + LIN_W'(eff_w);
            end
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RESET_WIDTH;
         height_ff   <= RESET_HEIGHT;
         recalc_ff   <= 1'b0;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_base_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_base_ff <= '0;
         owed_ff     <= 1'b0;
         b_valid_ff  <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         recalc_ff   <= csr_valid;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_base_ff  <= in_base_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_base_ff <= out_base_in;
         owed_ff     <= owed_in;
         b_valid_ff  <= req_fire && (!drain || emit);
      end
   end

   // second stage: line buffer data is back, shift the window
   assign b_wr    = b_valid_ff && b_pix_ff;
   assign top_eff = fwd_ff ? fwd_top_ff : top_rd_ff;
   assign mid_eff = fwd_ff ? fwd_mid_ff : mid_rd_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_pix_ff    <= !drain;
         b_emit_ff   <= emit;
         b_border_ff <= border;
         b_end_ff    <= out_col_wrap && out_row_wrap;
         b_col_ff    <= in_col_ff;
         b_gray_ff   <= gray;
         fwd_ff      <= b_wr && (b_col_ff == in_col_ff);
         fwd_top_ff  <= mid_eff;
         fwd_mid_ff  <= b_gray_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_wr) begin
         above_mem[b_col_ff]     <= b_gray_ff;
         two_above_mem[b_col_ff] <= mid_eff;
      end
      if (req_fire) begin
         top_rd_ff <= two_above_mem[in_col_ff];
         mid_rd_ff <= above_mem[in_col_ff];
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         win_next[i] = win_ff[i];
      end
      if (b_wr) begin
         win_next[0] = win_ff[1];
         win_next[1] = win_ff[2];
         win_next[2] = top_eff;
         win_next[3] = win_ff[4];
         win_next[4] = win_ff[5];
         win_next[5] = mid_eff;
         win_next[6] = win_ff[7];
         win_next[7] = win_ff[8];
         win_next[8] = b_gray_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         if (reset) begin
            win_ff[i] <= '0;
         end else begin
            win_ff[i] <= win_next[i];
         end
      end
   end

   assign gx_pos = SUM_W'(win_next[2]) + {1'b0, win_next[5], 1'b0} + SUM_W'(win_next[8]);
   assign gx_neg = SUM_W'(win_next[0]) + {1'b0, win_next[3], 1'b0} + SUM_W'(win_next[6]);
   assign gy_pos = SUM_W'(win_next[6]) + {1'b0, win_next[7], 1'b0} + SUM_W'(win_next[8]);
   assign gy_neg = SUM_W'(win_next[0]) + {1'b0, win_next[1], 1'b0} + SUM_W'(win_next[2]);

   always_comb begin
      q_entry.border    = b_border_ff;
      q_entry.frame_end = b_end_ff;
      q_entry.gx        = GRAD_W'(gx_pos) - GRAD_W'(gx_neg);
      q_entry.gy        = GRAD_W'(gy_pos) - GRAD_W'(gy_neg);
   end

endmodule

>>> src/sob_queue.sv
// Short queue of classified results between front and back ends.
module sob_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sob_pkg::q_entry_type        entry_in,
   input  logic                        pop,
   output logic                        valid,
   output sob_pkg::q_entry_type        entry_out,
   output logic [sob_pkg::QCNT_W-1:0]  count
);
   import sob_pkg::*;

   q_entry_type       slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign valid     = count_ff != '0;
   assign entry_out = slots_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

>>> src/sob_back.sv
// Back end: squares, iterative integer square root, clamp and result register.
module sob_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  sob_pkg::q_entry_type  q_entry,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sob_pkg::rsp_type      rsp_payload
);
   import sob_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [ABS_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic             border_ff, border_in, end_ff, end_in;
   logic [RT_W-1:0]  rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [GRAD_W-1:0] gx_abs, gy_abs;
   logic [SQ_W-1:0]   sq_sum;
   logic [RT_W-1:0]   trial;
   logic              out_free;

   assign gx_abs   = q_entry.gx[GRAD_W-1] ? GRAD_W'(-q_entry.gx) : GRAD_W'(q_entry.gx);
   assign gy_abs   = q_entry.gy[GRAD_W-1] ? GRAD_W'(-q_entry.gy) : GRAD_W'(q_entry.gy);
   assign sq_sum   = (SQ_W'(ax_ff) * SQ_W'(ax_ff)) + (SQ_W'(ay_ff) * SQ_W'(ay_ff));
   assign trial    = root_ff + bit_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      border_in    = border_ff;
      end_in       = end_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               ax_in     = gx_abs[ABS_W-1:0];
               ay_in     = gy_abs[ABS_W-1:0];
               border_in = q_entry.border;
               end_in    = q_entry.frame_end;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (border_ff) begin
               root_in  = '0;
               state_in = ST_OUT;
            end else if (sq_sum[SQ_W-1:RT_W] != '0) begin
               root_in  = RT_W'(MAG_MAX);
               state_in = ST_OUT;
            end else begin
               rem_in   = sq_sum[RT_W-1:0];
               root_in  = '0;
               bit_in   = ROOT_START;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == RT_W'(1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.edge_value = root_ff[PIX_W-1:0];
               rsp_data_in.frame_end  = end_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      border_ff   <= border_in;
      end_ff      <= end_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> src/sobel_edge_magnitude.sv
// Top level: 3x3 Sobel gradient magnitude over a raster pixel stream.
// Path to rsp_valid: front-end registers, the queue (with any wait there), then the back-end states.
// Throughput: beats without a result are taken one per cycle while the queue has room and no
// configuration write stalls input; the back end takes one result at a time, with 8 root steps
// unless it is a border or saturated result. A configuration write stalls input in the cycle after it.
// Synchronous active-high reset clears counters, window, queue and output; not the line buffers.
module sobel_edge_magnitude (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sob_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output sob_pkg::rsp_type               rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sob_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sob_pkg::DIM_W-1:0]      csr_wdata
);
   import sob_pkg::*;

   logic              q_push, q_pop, q_valid;
   logic [QCNT_W-1:0] q_count;
   q_entry_type       q_entry_in, q_entry_out;

   sob_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_count     (q_count),
      .q_push      (q_push),
      .q_entry     (q_entry_in)
   );

   sob_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .entry_in  (q_entry_in),
      .pop       (q_pop),
      .valid     (q_valid),
      .entry_out (q_entry_out),
      .count     (q_count)
   );

   sob_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_entry     (q_entry_out),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |-> (q_count != QCNT_W'(QUEUE_DEPTH)))
      else $error("push into a full queue");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (q_count <= QCNT_W'(QUEUE_DEPTH)))
      else $error("queue count beyond depth");
`endif

endmodule
